@@ hdl/bltd_pkg.sv @@
// Shared types, codes and helper functions for the bytecode line table decoder.
// Used by the state, result and top level modules; depends on nothing else.
package bltd_pkg;

    localparam int LINE_BITS = 32;
    localparam int COL_BITS  = 16;

    localparam logic [COL_BITS-1:0] COL_MAX = '1;
    localparam logic [32:0]         SUM_CAP = 33'h1_0000_0000;

    localparam logic [1:0] FUNC_START  = 2'd0;
    localparam logic [1:0] FUNC_BYTE   = 2'd1;
    localparam logic [1:0] FUNC_FINISH = 2'd2;

    localparam logic [1:0] FMT_OLD     = 2'd0;
    localparam logic [1:0] FMT_PAIRED  = 2'd1;
    localparam logic [1:0] FMT_LOC     = 2'd2;
    localparam logic [1:0] FMT_LOC_ALT = 2'd3;

    localparam logic [3:0] CODE_ONE_MIN  = 4'd10;
    localparam logic [3:0] CODE_LONG_MIN = 4'd13;
    localparam logic [3:0] CODE_LONG     = 4'd14;
    localparam logic [3:0] CODE_NONE     = 4'd15;

    localparam logic [7:0] STOP_MARK = 8'hff;
    localparam logic [7:0] NO_DELTA  = 8'h80;

    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_LINE   = 8'b0000_0010,
        PH_END    = 8'b0000_0100,
        PH_COL    = 8'b0000_1000,
        PH_COLEND = 8'b0001_0000,
        PH_SHORT  = 8'b0010_0000,
        PH_ONE1   = 8'b0100_0000,
        PH_ONE2   = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [1:0]         func;
        logic [7:0]         table_byte;
        logic [31:0]        first_line;
        logic signed [31:0] target_offset;
    } t_in_item;

    typedef struct packed {
        logic [LINE_BITS-1:0] line;
        logic [LINE_BITS-1:0] last_line;
        logic [COL_BITS-1:0]  column;
        logic [COL_BITS-1:0]  last_column;
        logic                 status;
    } t_out_item;

    typedef struct packed {
        logic loc;
        logic paired;
    } t_fmt_sel;

    typedef struct packed {
        logic [LINE_BITS-1:0] line_acc;
        logic [32:0]          offset_sum;
        logic signed [31:0]   target;
        logic                 frozen;
        logic [3:0]           code;
        t_phase               phase;
        logic [31:0]          vval;
        logic [5:0]           vshift;
        logic [7:0]           pair_first;
        logic                 pair_pending;
        logic [LINE_BITS-1:0] loc_line;
        logic [LINE_BITS-1:0] loc_last_line;
        logic [COL_BITS-1:0]  loc_col;
        logic [COL_BITS-1:0]  loc_col_end;
    } t_dec_state;

    function automatic logic [COL_BITS-1:0] f_col_sat(logic [31:0] v);
        return (v > 32'(COL_MAX)) ? COL_MAX : v[COL_BITS-1:0];
    endfunction

    // Zigzag line delta: bit 0 is the sign, the rest the magnitude.
    function automatic logic [LINE_BITS-1:0] f_zz_delta(logic [31:0] v);
        logic [31:0] mag;
        mag = {1'b0, v[31:1]};
        return v[0] ? LINE_BITS'(~mag + 32'd1) : LINE_BITS'(mag);
    endfunction

endpackage

@@ hdl/bytecode_line_table_decoder_core.sv @@
// Top level of the bytecode line table decoder: input register, format register,
// decoder state, result formation and output register. Depends on bltd_pkg,
// bltd_state and bltd_result.
//
// Usage. Items arrive on the input channel (i_in_valid, o_in_ready, i_in_item):
// a start item loads the first line and the sought bytecode position, table
// byte items follow, and a finish item produces one result on the output
// channel (o_out_valid, i_out_ready, o_out_item). Start and byte items produce
// no result. The table layout is set through i_cfg_we and i_cfg_wdata; the user
// must write it only while the block is idle, which the block does not enforce.
// It resets to the varint location table. A finish item waits in the input
// register until the output register is free, and is then decoded into it.
// Throughput: one item per cycle while no finish item waits, set by the single
// input register feeding the decoder state update. While the output register
// holds a result that has not been taken, start and byte items keep flowing;
// only a following finish item waits in the input register. Reset clears the
// decoder state and both valid flags; there is no clearing pass.
module bytecode_line_table_decoder_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bltd_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bltd_pkg::t_out_item  o_out_item
);
    import bltd_pkg::*;

    logic [1:0] r_fmt;
    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;

    t_fmt_sel   fmt_sel;
    t_dec_state dec_state;
    t_out_item  result;
    logic       out_free;
    logic       advance;
    logic       is_finish;

    assign fmt_sel.loc    = (r_fmt == FMT_LOC) || (r_fmt == FMT_LOC_ALT);
    assign fmt_sel.paired = (r_fmt == FMT_PAIRED);

    assign is_finish  = (r_in.func == FUNC_FINISH);
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!is_finish || out_free);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_LOC;
        end else if (i_cfg_we) begin
            r_fmt <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    bltd_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in),
        .i_fmt   (fmt_sel),
        .o_state (dec_state)
    );

    bltd_result u_result (
        .i_state (dec_state),
        .i_fmt   (fmt_sel),
        .o_item  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && is_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && is_finish) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid) && $past(r_in.func) == FUNC_FINISH)
        else $error("result appeared without a finish item");

    a_finish_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && is_finish && r_out_valid && !i_out_ready |=> r_in_valid
            && r_in.func == FUNC_FINISH && r_out_valid)
        else $error("finish item lost while the output was stalled");

    a_bytes_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !is_finish |-> o_in_ready)
        else $error("non-finish item stalled the input");

endmodule

@@ hdl/bltd_state.sv @@
// Decoder state register and its per-item update for all three table layouts.
// Depends on bltd_pkg.
module bltd_state (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  bltd_pkg::t_in_item    i_item,
    input  bltd_pkg::t_fmt_sel    i_fmt,
    output bltd_pkg::t_dec_state  o_state
);
    import bltd_pkg::*;

    t_dec_state r_st;
    t_dec_state n_st;

    function automatic logic [32:0] f_add_off(logic [32:0] sum, logic [7:0] n);
        logic [33:0] s;
        s = {1'b0, sum} + {26'b0, n};
        return (s > {1'b0, SUM_CAP}) ? SUM_CAP : s[32:0];
    endfunction

    function automatic logic f_beyond(logic [32:0] sum, logic signed [31:0] tgt, logic dbl);
        logic signed [33:0] s;
        logic signed [33:0] t;
        s = $signed({1'b0, sum});
        t = dbl ? $signed({tgt[31], tgt, 1'b0}) : $signed({{2{tgt[31]}}, tgt});
        return s > t;
    endfunction

    logic [7:0]           b;
    logic [32:0]          off_new;
    logic [31:0]          chunk;
    logic [31:0]          vfull;
    logic [31:0]          c_start;
    logic [31:0]          c_end;
    logic [LINE_BITS-1:0] sext_b;
    logic [LINE_BITS-1:0] one_delta;
    logic [3:0]           hdr_code;

    always_comb begin
        b         = i_item.table_byte;
        hdr_code  = b[6:3];
        chunk     = (r_st.vshift < 6'd32) ? ({26'b0, b[5:0]} << r_st.vshift[4:0]) : 32'd0;
        vfull     = r_st.vval | chunk;
        c_start   = 32'd1 + {25'b0, r_st.code, 3'b0} + {29'b0, b[6:4]};
        c_end     = c_start + {28'b0, b[3:0]};
        sext_b    = {{(LINE_BITS-8){b[7]}}, b};
        one_delta = (r_st.code >= CODE_ONE_MIN) ?
                    LINE_BITS'(r_st.code - CODE_ONE_MIN) : '0;
        off_new   = f_add_off(r_st.offset_sum,
                              i_fmt.loc ? {5'b0, b[2:0]} + 8'd1 : b);

        n_st = r_st;
        if (i_step && i_item.func == FUNC_START) begin
            n_st          = '0;
            n_st.phase    = PH_IDLE;
            n_st.line_acc = LINE_BITS'(i_item.first_line);
            n_st.target   = i_item.target_offset;
        end else if (i_step && i_item.func == FUNC_BYTE && !r_st.frozen) begin
            if (i_fmt.loc) begin
                unique case (r_st.phase)
                    PH_IDLE: begin
                        n_st.offset_sum = off_new;
                        n_st.code       = hdr_code;
                        n_st.vval       = '0;
                        n_st.vshift     = '0;
                        if (hdr_code == CODE_NONE) begin
                            n_st.frozen = f_beyond(off_new, r_st.target, 1'b0);
                        end else if (hdr_code >= CODE_LONG_MIN) begin
                            n_st.phase = PH_LINE;
                        end else if (hdr_code >= CODE_ONE_MIN) begin
                            n_st.phase = PH_ONE1;
                        end else begin
                            n_st.phase = PH_SHORT;
                        end
                    end
                    PH_SHORT: begin
                        n_st.loc_line      = r_st.line_acc;
                        n_st.loc_last_line = r_st.line_acc;
                        n_st.loc_col       = f_col_sat(c_start);
                        n_st.loc_col_end   = f_col_sat(c_end);
                        n_st.phase         = PH_IDLE;
                        n_st.frozen        = f_beyond(r_st.offset_sum, r_st.target, 1'b0);
                    end
                    PH_ONE1: begin
                        n_st.pair_first = b;
                        n_st.phase      = PH_ONE2;
                    end
                    PH_ONE2: begin
                        n_st.line_acc      = r_st.line_acc + one_delta;
                        n_st.loc_line      = r_st.line_acc + one_delta;
                        n_st.loc_last_line = r_st.line_acc + one_delta;
                        n_st.loc_col       = f_col_sat(32'd1 + {24'b0, r_st.pair_first});
                        n_st.loc_col_end   = f_col_sat(32'd1 + {24'b0, b});
                        n_st.phase         = PH_IDLE;
                        n_st.frozen        = f_beyond(r_st.offset_sum, r_st.target, 1'b0);
                    end
                    PH_LINE, PH_END, PH_COL, PH_COLEND: begin
                        if (b[6]) begin
                            n_st.vval = vfull;
                            if (r_st.vshift < 6'd32) begin
                                n_st.vshift = r_st.vshift + 6'd6;
                            end
                        end else begin
                            n_st.vval   = '0;
                            n_st.vshift = '0;
                            unique case (r_st.phase)
                                PH_LINE: begin
                                    n_st.line_acc      = r_st.line_acc + f_zz_delta(vfull);
                                    n_st.loc_line      = r_st.line_acc + f_zz_delta(vfull);
                                    n_st.loc_last_line = r_st.line_acc + f_zz_delta(vfull);
                                    n_st.loc_col       = '0;
                                    n_st.loc_col_end   = '0;
                                    if (r_st.code == CODE_LONG) begin
                                        n_st.phase = PH_END;
                                    end else begin
                                        n_st.phase  = PH_IDLE;
                                        n_st.frozen = f_beyond(r_st.offset_sum,
                                                               r_st.target, 1'b0);
                                    end
                                end
                                PH_END: begin
                                    n_st.loc_last_line = r_st.line_acc + LINE_BITS'(vfull);
                                    n_st.phase         = PH_COL;
                                end
                                PH_COL: begin
                                    n_st.loc_col = f_col_sat(vfull);
                                    n_st.phase   = PH_COLEND;
                                end
                                default: begin
                                    n_st.loc_col_end = f_col_sat(vfull);
                                    n_st.phase       = PH_IDLE;
                                    n_st.frozen      = f_beyond(r_st.offset_sum,
                                                                r_st.target, 1'b0);
                                end
                            endcase
                        end
                    end
                    default: begin
                        n_st = r_st;
                    end
                endcase
            end else if (!r_st.pair_pending) begin
                if (i_fmt.paired) begin
                    if (b == STOP_MARK) begin
                        n_st.frozen = 1'b1;
                    end else begin
                        n_st.offset_sum   = off_new;
                        n_st.pair_first   = b;
                        n_st.pair_pending = 1'b1;
                    end
                end else begin
                    n_st.offset_sum = off_new;
                    if (f_beyond(off_new, r_st.target, 1'b0)) begin
                        n_st.frozen = 1'b1;
                    end else begin
                        n_st.pair_pending = 1'b1;
                    end
                end
            end else begin
                n_st.pair_pending = 1'b0;
                if (i_fmt.paired) begin
                    n_st.line_acc = r_st.line_acc + ((b == NO_DELTA) ? '0 : sext_b);
                    n_st.frozen   = f_beyond(r_st.offset_sum, r_st.target, 1'b1);
                end else begin
                    n_st.line_acc = r_st.line_acc + sext_b;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= '0;
            r_st.phase <= PH_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_state = r_st;

    a_frozen_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.frozen && i_step && i_item.func == FUNC_BYTE |=> $stable(r_st))
        else $error("frozen decoder state changed on a table byte");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.func == FUNC_START |=> !r_st.frozen && r_st.phase == PH_IDLE
            && !r_st.pair_pending && r_st.offset_sum == '0)
        else $error("start did not clear the decoder state");

endmodule

@@ hdl/bltd_result.sv @@
// Result on finish: completes cut long entries; flags cut short and one-line ones.
// Depends on bltd_pkg.
module bltd_result (
    input  bltd_pkg::t_dec_state i_state,
    input  bltd_pkg::t_fmt_sel   i_fmt,
    output bltd_pkg::t_out_item  o_item
);
    import bltd_pkg::*;

    logic [LINE_BITS-1:0] line_next;

    always_comb begin
        line_next          = i_state.line_acc + f_zz_delta(i_state.vval);
        o_item.line        = i_state.loc_line;
        o_item.last_line   = i_state.loc_last_line;
        o_item.column      = i_state.loc_col;
        o_item.last_column = i_state.loc_col_end;
        o_item.status      = 1'b0;
        if (!i_fmt.loc) begin
            o_item.line        = i_state.line_acc;
            o_item.last_line   = i_state.line_acc;
            o_item.column      = '0;
            o_item.last_column = '0;
        end else if (!i_state.frozen) begin
            unique case (i_state.phase)
                PH_IDLE: begin
                    o_item.status = 1'b0;
                end
                PH_LINE: begin
                    o_item.line        = line_next;
                    o_item.last_line   = line_next;
                    o_item.column      = '0;
                    o_item.last_column = '0;
                end
                PH_END: begin
                    o_item.last_line   = i_state.line_acc + LINE_BITS'(i_state.vval);
                    o_item.column      = '0;
                    o_item.last_column = '0;
                end
                PH_COL: begin
                    o_item.column      = f_col_sat(i_state.vval);
                    o_item.last_column = '0;
                end
                PH_COLEND: begin
                    o_item.last_column = f_col_sat(i_state.vval);
                end
                default: begin
                    o_item.status = 1'b1;
                end
            endcase
        end
    end

endmodule
